@@ rtl/allm_pkg.sv @@
// shared types and constants for the array linked list manager
`default_nettype none

package allm_pkg;

  // field widths of the stream payloads
  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // request codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND  = 2'd0,
    ACT_PREPEND = 2'd1,
    ACT_READ    = 2'd2,
    ACT_LENGTH  = 2'd3
  } action_t;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;

  // list walk sequencer
  typedef enum logic {
    WALK_IDLE = 1'b0,
    WALK_RUN  = 1'b1
  } walk_state_t;

endpackage

`default_nettype wire

@@ rtl/array_linked_list_manager.sv @@
// array backed singly linked list with append, prepend, read-out and length
// insert and length: result is registered and valid in the cycle after the input transfer
// read-out: the first element goes through the registered read of the value and link memories
//   and then the output register; after that one element per cycle unless the output stalls
// a new input is taken once the walk is done and the output register is free
// reset clears the fill count, pointers, walk state and output valid; the
//   value and link memories are not cleared
`default_nettype none

module array_linked_list_manager #(
  parameter int CAPACITY = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [1:0] action, [33:2] value, [39:34] zero
  input  wire logic [allm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [31:0] item, [33:32] status, [38:34] count, [39] zero
  output logic [allm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic                                   m_axis_tlast
);
  import allm_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // storage: slots fill in order since entries are never removed
  logic signed [VALUE_W-1:0] value_mem [CAPACITY];
  logic [IW-1:0]             link_mem  [CAPACITY];

  walk_state_t state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] remaining;
  logic [IW-1:0] head, tail;

  // registered memory read data
  logic signed [VALUE_W-1:0] rd_value;
  logic [IW-1:0]             rd_link;

  // output register
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_item;
  logic [STATUS_W-1:0]       out_status;
  logic [COUNT_W-1:0]        out_count;
  logic                      out_last;

  // input decode
  action_t                   in_action;
  logic signed [VALUE_W-1:0] in_value;
  logic accept, out_free, full, empty;
  logic [IW-1:0] slot;

  // control decisions
  logic                      rd_en;
  logic [IW-1:0]             rd_addr;
  logic                      load;
  logic signed [VALUE_W-1:0] load_item;
  logic [STATUS_W-1:0]       load_status;
  logic                      load_last;
  logic                      ins_ok;
  logic                      val_we;
  logic                      link_we;
  logic [IW-1:0]             link_waddr;
  logic [IW-1:0]             link_wdata;
  logic                      walk_start;

  assign in_action = action_t'(s_axis_tdata[ACTION_W-1:0]);
  assign in_value  = s_axis_tdata[ACTION_W +: VALUE_W];
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid || m_axis_tready;
  assign full      = (fill == CW'(CAPACITY));
  assign empty     = (fill == '0);
  assign slot      = fill[IW-1:0];
  assign fill_next = fill + CW'(ins_ok);

  // input ready while idle and the output register can take a result
  assign s_axis_tready = (state == WALK_IDLE) && out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      WALK_IDLE: if (walk_start) state_next = WALK_RUN;
      WALK_RUN:  if (out_free && remaining == CW'(1)) state_next = WALK_IDLE;
      default:   state_next = WALK_IDLE;
    endcase
  end

  // control outputs per state
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = head;
    load        = 1'b0;
    load_item   = '0;
    load_status = STS_OK;
    load_last   = 1'b1;
    ins_ok      = 1'b0;
    val_we      = 1'b0;
    link_we     = 1'b0;
    link_waddr  = slot;
    link_wdata  = head;
    walk_start  = 1'b0;
    case (state)
      WALK_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_APPEND, ACT_PREPEND: begin
              load = 1'b1;
              if (full) begin
                load_status = STS_FULL;
              end else begin
                ins_ok = 1'b1;
                val_we = 1'b1;
                // prepend links the new slot to the head, append links the tail to it
                if (!empty) begin
                  link_we = 1'b1;
                  if (in_action == ACT_APPEND) begin
                    link_waddr = tail;
                    link_wdata = slot;
                  end
                end
              end
            end
            ACT_READ: begin
              if (empty) begin
                load        = 1'b1;
                load_status = STS_EMPTY;
              end else begin
                rd_en      = 1'b1;
                walk_start = 1'b1;
              end
            end
            default: load = 1'b1;
          endcase
        end
      end
      WALK_RUN: begin
        // follow the link of the element just read
        rd_addr = rd_link;
        if (out_free) begin
          load      = 1'b1;
          load_item = rd_value;
          load_last = (remaining == CW'(1));
          rd_en     = (remaining != CW'(1));
        end
      end
      default: ;
    endcase
  end

  // memories: inserts and walks never overlap, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[slot] <= in_value;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (rd_en) begin
      rd_value <= value_mem[rd_addr];
      rd_link  <= link_mem[rd_addr];
    end
  end

  // list control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= WALK_IDLE;
      fill      <= '0;
      remaining <= '0;
      head      <= '0;
      tail      <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (ins_ok) begin
        if (empty) begin
          head <= slot;
          tail <= slot;
        end else if (in_action == ACT_APPEND) begin
          tail <= slot;
        end else begin
          head <= slot;
        end
      end
      if (walk_start) begin
        remaining <= fill;
      end else if (state == WALK_RUN && out_free) begin
        remaining <= remaining - CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item   <= load_item;
      out_status <= load_status;
      out_count  <= COUNT_W'(fill_next);
      out_last   <= load_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {1'b0, out_count, out_status, out_item};

endmodule

`default_nettype wire

@@ rtl/allm_checker.sv @@
// port level checks for the array linked list manager
`default_nettype none

module allm_checker #(
  parameter int CAPACITY = 16
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [allm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input wire logic                              m_axis_tlast
);
  import allm_pkg::*;

  logic [STATUS_W-1:0] sts;
  logic [COUNT_W-1:0]  cnt;
  logic [VALUE_W-1:0]  itm;

  assign sts = m_axis_tdata[VALUE_W +: STATUS_W];
  assign cnt = m_axis_tdata[VALUE_W + STATUS_W +: COUNT_W];
  assign itm = m_axis_tdata[VALUE_W-1:0];

  // a stalled result transfer holds its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // no new request is taken in the middle of a read-out
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken during read-out");

  // a full report carries the full count
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && sts == STS_FULL |-> cnt == COUNT_W'(CAPACITY) && m_axis_tlast)
    else $error("full status with wrong count");

  // an empty report is a lone result with zero count and item
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && sts == STS_EMPTY |-> cnt == '0 && itm == '0 && m_axis_tlast)
    else $error("malformed empty result");

  // only read-out elements carry a nonzero item
  a_item_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && itm != '0 |-> sts == STS_OK && cnt != '0)
    else $error("item data on a non read-out result");

endmodule

bind array_linked_list_manager allm_checker #(.CAPACITY(CAPACITY)) u_allm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// self-checking testbench for the array linked list manager
`timescale 1ns / 100ps

// one result transfer as the predictor expects it
typedef struct packed {
  logic [31:0] item;
  logic [1:0]  status;
  logic [4:0]  count;
  logic        last;
} list_result_t;

// predictor of the list contents and store of expected result transfers
class list_scoreboard;
  localparam int CAPACITY = 16;
  localparam int NULL_IDX = CAPACITY;

  logic [31:0]  value_mem [CAPACITY];
  int           next_mem [CAPACITY];
  bit           slot_taken [CAPACITY];
  int           head_slot;
  int           tail_slot;
  list_result_t expected [$];
  int           mismatches;
  int           results_checked;
  int           requests_seen;
  bit           full_seen;

  function new();
    for (int i = 0; i < CAPACITY; i++) begin
      value_mem[i]  = '0;
      next_mem[i]   = 0;
      slot_taken[i] = 1'b0;
    end
    head_slot       = NULL_IDX;
    tail_slot       = NULL_IDX;
    mismatches      = 0;
    results_checked = 0;
    requests_seen   = 0;
    full_seen       = 1'b0;
  endfunction

  // entries reachable from the head, bounded by the capacity
  function int list_length();
    int n;
    int idx;
    n   = 0;
    idx = head_slot;
    while (idx < NULL_IDX && n < CAPACITY) begin
      n++;
      idx = next_mem[idx];
    end
    return n;
  endfunction

  function void push_result(logic [31:0] item, logic [1:0] status, int count, bit last);
    list_result_t r;
    r.item   = item;
    r.status = status;
    r.count  = count[4:0];
    r.last   = last;
    expected.push_back(r);
  endfunction

  // update the list for one accepted request and queue its results
  function void note_request(allm_pkg::action_t act, logic [31:0] val);
    int slot;
    int n;
    int idx;
    int k;
    requests_seen++;
    case (act)
      allm_pkg::ACT_APPEND, allm_pkg::ACT_PREPEND: begin
        // lowest free slot wins
        slot = NULL_IDX;
        for (int i = CAPACITY - 1; i >= 0; i--)
          if (!slot_taken[i]) slot = i;
        if (slot == NULL_IDX) begin
          full_seen = 1'b1;
          push_result('0, allm_pkg::STS_FULL, list_length(), 1'b1);
        end else begin
          value_mem[slot]  = val;
          slot_taken[slot] = 1'b1;
          if (head_slot == NULL_IDX || tail_slot == NULL_IDX) begin
            // first entry is head and tail at once
            next_mem[slot] = NULL_IDX;
            head_slot      = slot;
            tail_slot      = slot;
          end else if (act == allm_pkg::ACT_APPEND) begin
            next_mem[slot]      = NULL_IDX;
            next_mem[tail_slot] = slot;
            tail_slot           = slot;
          end else begin
            next_mem[slot] = head_slot;
            head_slot      = slot;
          end
          push_result('0, allm_pkg::STS_OK, list_length(), 1'b1);
        end
      end
      allm_pkg::ACT_READ: begin
        n = list_length();
        if (n == 0) begin
          push_result('0, allm_pkg::STS_EMPTY, 0, 1'b1);
        end else begin
          idx = head_slot;
          for (k = 0; k < n && idx < NULL_IDX; k++) begin
            push_result(value_mem[idx], allm_pkg::STS_OK, n, (k + 1 == n));
            idx = next_mem[idx];
          end
        end
      end
      default: begin
        push_result('0, allm_pkg::STS_OK, list_length(), 1'b1);
      end
    endcase
  endfunction

  // compare one output transfer with the oldest expectation
  function void check_result(logic [allm_pkg::OUT_TDATA_W-1:0] tdata, logic tlast);
    list_result_t got;
    list_result_t want;
    got.item   = tdata[31:0];
    got.status = tdata[33:32];
    got.count  = tdata[38:34];
    got.last   = tlast;
    if (expected.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected result item=%h status=%0d count=%0d last=%0b",
                 $realtime, got.item, got.status, got.count, got.last);
      mismatches++;
      return;
    end
    want = expected.pop_front();
    results_checked++;
    if (got.item !== want.item || got.status !== want.status ||
        got.count !== want.count || got.last !== want.last) begin
      if (mismatches < 10)
        $display("%0t: mismatch item %h/%h status %0d/%0d count %0d/%0d last %0b/%0b (exp/act)",
                 $realtime, want.item, got.item, want.status, got.status,
                 want.count, got.count, want.last, got.last);
      mismatches++;
    end
  endfunction
endclass

module tb_top;
  import allm_pkg::*;

  localparam int RANDOM_ITEMS = 170;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // [1:0] action, [33:2] value, [39:34] zero
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // [31:0] item, [33:32] status, [38:34] count, [39] zero
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tlast;

  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  list_scoreboard board;

  array_linked_list_manager i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: check each transfer, then pick the next ready
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // request side: optional idle gap, then hold the request until its transfer
  task automatic send_request(input action_t act, input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, val, act};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_request(act, val);
  endtask

  // main sequence
  initial begin
    action_t     act;
    logic [31:0] val;
    int          pick;
    int          phase;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list cases, first insert, field extremes
    send_request(ACT_READ,    32'h0000_0000);
    send_request(ACT_LENGTH,  32'hFFFF_FFFF);
    send_request(ACT_PREPEND, 32'h8000_0000);
    send_request(ACT_READ,    32'h1234_5678);
    send_request(ACT_APPEND,  32'h7FFF_FFFF);
    send_request(ACT_PREPEND, 32'hFFFF_FFFF);
    send_request(ACT_APPEND,  32'h0000_0000);
    send_request(ACT_PREPEND, 32'h0000_0001);
    send_request(ACT_APPEND,  32'hAAAA_AAAA);
    send_request(ACT_PREPEND, 32'h5555_5555);
    send_request(ACT_READ,    32'h0000_0000);
    send_request(ACT_LENGTH,  32'h0000_0000);

    // random: the list fills up gradually, then full inserts mix with reads
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      phase = (i * 4) / RANDOM_ITEMS;
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      pick = $urandom_range(99);
      if (pick < 22)
        act = ($urandom_range(1) == 0) ? ACT_APPEND : ACT_PREPEND;
      else if (pick < 66)
        act = ACT_READ;
      else
        act = ACT_LENGTH;
      case ($urandom_range(7))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = ($urandom_range(1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        default: val = $urandom;
      endcase
      send_request(act, val);
    end
    s_axis_tvalid <= 1'b0;

    // drain, then keep watching for stray transfers
    while (board.expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("requests sent: %0d, result transfers checked: %0d, mismatches: %0d",
             board.requests_seen, board.results_checked, board.mismatches);
    $display("list reached capacity and refused inserts: %0s",
             board.full_seen ? "yes" : "no");
    if (board.mismatches == 0 && board.expected.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", board.expected.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/allm_pkg.sv
rtl/array_linked_list_manager.sv
rtl/allm_checker.sv
sim/tb_top.sv
